[sv/rq_pkg.sv]
// ============================================================================
// rq_pkg : shared constants and types for the Q31 requantizer
// Register map, reset values and arithmetic constants of the int32-to-int8
// requantization pipeline.
// ============================================================================
package rq_pkg;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SCALE_WORD = 2'd0;
    localparam logic [1:0] REG_OUT_ZERO   = 2'd1;
    localparam logic [1:0] REG_OUT_MIN    = 2'd2;
    localparam logic [1:0] REG_OUT_MAX    = 2'd3;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // field widths
    localparam int ACC_W   = 32;
    localparam int SCALE_W = 30;
    localparam int MANT_W  = 23;
    localparam int EXP_W   = SCALE_W - MANT_W;
    localparam int PROD_W  = 56;   // |acc * m24| < 2^55
    localparam int Q_W     = 32;
    localparam int SH_W    = 5;

    // reset values
    localparam logic [SCALE_W-1:0] RST_SCALE_WORD = 30'h3F00_0000;
    localparam logic signed [7:0]  RST_OUT_ZERO   = 8'sd0;
    localparam logic signed [7:0]  RST_OUT_MIN    = -8'sd128;
    localparam logic signed [7:0]  RST_OUT_MAX    = 8'sd127;

    // arithmetic constants
    localparam logic [MANT_W-1:0] MANT_MASK  = 23'h7F_FFFF;
    localparam logic [MANT_W:0]   HIDDEN_BIT = 24'h80_0000;
    // (acc * (m24 << 7) + 2^30) >> 31  ==  (acc * m24 + 2^23) >> 24
    localparam logic signed [PROD_W-1:0] PROD_RND = 56'sh80_0000;
    localparam int PROD_SHIFT = 24;
    localparam logic [EXP_W-1:0] SHIFT_BASE = 7'd126;   // 127 + 31 - 32
    localparam logic [EXP_W-1:0] EXP_MIN    = 7'd95;    // below: shift > 31

    typedef logic signed [7:0] t_int8;
    typedef logic signed [15:0] t_int16;

endpackage

[sv/q31_requantize_int32_to_int8.sv]
// ============================================================================
// q31_requantize_int32_to_int8 : Q31 requantizer, int32 accumulator to int8
// Five-stage pipeline: multiply, Q31 round, rounding right shift, 16-bit
// saturation, zero point add with int8 saturation and output clamp.
// ============================================================================
// Input   : i_valid / o_stall with i_acc, i_last_in; a beat is taken on a
//           rising edge with i_valid high and o_stall low.
// Output  : o_valid / i_stall with o_value, o_last_out; a beat leaves on a
//           rising edge with o_valid high and i_stall low.
// Config  : APB-style, pready tied high, registers at 4*index: 0 scale word,
//           1 zero point, 2 out_min, 3 out_max. Write only with the pipe empty.
// Stages  : five register stages, stage 1 to stage 5; a beat taken into stage 1
//           passes through each stage in turn and leaves from stage 5 on o_valid.
// Rate    : one beat per cycle, back to back, while i_stall is low; the 32x24 multiplier (stage 1)
//           and the 56-bit round add (stage 2) set the clock period.
// Reset   : synchronous, active low; clears every stage valid and loads
//           scale 0.5, zero point 0, bounds -128..127.
// Stall   : a stage advances when empty or when the stage after it advances,
//           so bubbles collapse; with all five stages full and i_stall high,
//           o_stall rises and nothing moves.
// ============================================================================
module q31_requantize_int32_to_int8 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rq_pkg::ACC_W-1:0]     i_acc,
    input  logic                                i_last_in,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [7:0]                   o_value,
    output logic                                o_last_out,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rq_pkg::PADDR_W-1:0]          paddr,
    input  logic [rq_pkg::PDATA_W-1:0]          pwdata,
    output logic [rq_pkg::PDATA_W-1:0]          prdata,
    output logic                                pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [rq_pkg::SCALE_W-1:0] r_scale_word;
    rq_pkg::t_int8              r_out_zero;
    rq_pkg::t_int8              r_out_min;
    rq_pkg::t_int8              r_out_max;
    logic                       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_word <= rq_pkg::RST_SCALE_WORD;
            r_out_zero   <= rq_pkg::RST_OUT_ZERO;
            r_out_min    <= rq_pkg::RST_OUT_MIN;
            r_out_max    <= rq_pkg::RST_OUT_MAX;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                rq_pkg::REG_SCALE_WORD: r_scale_word <= pwdata[rq_pkg::SCALE_W-1:0];
                rq_pkg::REG_OUT_ZERO:   r_out_zero   <= pwdata[7:0];
                rq_pkg::REG_OUT_MIN:    r_out_min    <= pwdata[7:0];
                rq_pkg::REG_OUT_MAX:    r_out_max    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // reads zero-extend the raw register bits
    always_comb begin
        case (paddr[3:2])
            rq_pkg::REG_SCALE_WORD:
                prdata = {{(rq_pkg::PDATA_W-rq_pkg::SCALE_W){1'b0}}, r_scale_word};
            rq_pkg::REG_OUT_ZERO:   prdata = {24'd0, r_out_zero};
            rq_pkg::REG_OUT_MIN:    prdata = {24'd0, r_out_min};
            rq_pkg::REG_OUT_MAX:    prdata = {24'd0, r_out_max};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // values derived from the scale (user must keep them static while items are in flight; not enforced)
    // ------------------------------------------------------------------
    logic [rq_pkg::MANT_W:0]    w_m24;
    logic [rq_pkg::EXP_W-1:0]   w_exp;
    logic [rq_pkg::EXP_W-1:0]   w_sh_full;
    logic [rq_pkg::SH_W-1:0]    w_sh;
    logic                       w_sh_zero;   // shift past 31: result is 0

    assign w_m24     = (r_scale_word[rq_pkg::MANT_W-1:0] & rq_pkg::MANT_MASK)
                       | rq_pkg::HIDDEN_BIT;
    assign w_exp     = r_scale_word[rq_pkg::SCALE_W-1:rq_pkg::MANT_W];
    assign w_sh_full = rq_pkg::SHIFT_BASE - w_exp;
    assign w_sh_zero = (w_exp < rq_pkg::EXP_MIN);
    // exponent 127 (scale of one or more) would be negative: pin to zero
    assign w_sh      = (w_exp > rq_pkg::SHIFT_BASE) ? '0 : w_sh_full[rq_pkg::SH_W-1:0];

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5   = !r_v5 || !i_stall;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: acc * m24 (32 x 24 signed-by-unsigned)
    // operands extended to the product width; the product always fits
    // ------------------------------------------------------------------
    logic signed [rq_pkg::PROD_W-1:0]   w_acc_x;
    logic signed [rq_pkg::PROD_W-1:0]   w_m_x;
    logic signed [rq_pkg::PROD_W-1:0]   n_p;
    logic signed [rq_pkg::PROD_W-1:0]   r_p;
    logic                               r_l1;

    assign w_acc_x = {{(rq_pkg::PROD_W-rq_pkg::ACC_W){i_acc[rq_pkg::ACC_W-1]}}, i_acc};
    assign w_m_x   = {{(rq_pkg::PROD_W-rq_pkg::MANT_W-1){1'b0}}, w_m24};
    assign n_p     = w_acc_x * w_m_x;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_p  <= n_p;
            r_l1 <= i_last_in;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: Q31 rounding, q = (p + 2^23) >>> 24
    // ------------------------------------------------------------------
    logic signed [rq_pkg::PROD_W-1:0]   n_sum2;
    logic signed [rq_pkg::Q_W-1:0]      r_q;
    logic                               r_l2;

    assign n_sum2 = r_p + rq_pkg::PROD_RND;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_q  <= n_sum2[rq_pkg::PROD_SHIFT+rq_pkg::Q_W-1:rq_pkg::PROD_SHIFT];
            r_l2 <= r_l1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: arithmetic shift, round half away from zero decision
    // ------------------------------------------------------------------
    logic [rq_pkg::Q_W-1:0]             w_mask;
    logic [rq_pkg::Q_W-1:0]             w_rem;
    logic [rq_pkg::Q_W-1:0]             w_thr;
    logic signed [rq_pkg::Q_W-1:0]      n_fl;
    logic                               n_rnd;
    logic signed [rq_pkg::Q_W-1:0]      r_fl;
    logic                               r_rnd;
    logic                               r_l3;

    assign w_mask = ~({rq_pkg::Q_W{1'b1}} << w_sh);
    assign w_rem  = r_q & w_mask;
    // negative values round up only strictly past the half
    assign w_thr  = {1'b0, w_mask[rq_pkg::Q_W-1:1]} + {{(rq_pkg::Q_W-1){1'b0}}, r_q[rq_pkg::Q_W-1]};

    always_comb begin
        if (w_sh_zero) begin
            n_fl  = '0;
            n_rnd = 1'b0;
        end else begin
            n_fl  = r_q >>> w_sh;
            n_rnd = (w_rem > w_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_fl  <= n_fl;
            r_rnd <= n_rnd;
            r_l3  <= r_l2;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: apply rounding, saturate to 16 bits
    // ------------------------------------------------------------------
    logic signed [rq_pkg::Q_W:0]    w_sum4;
    rq_pkg::t_int16                 n_s16;
    rq_pkg::t_int16                 r_s16;
    logic                           r_l4;

    assign w_sum4 = {r_fl[rq_pkg::Q_W-1], r_fl} + {{rq_pkg::Q_W{1'b0}}, r_rnd};

    always_comb begin
        if (w_sum4 > 33'sd32767)
            n_s16 = 16'sh7FFF;
        else if (w_sum4 < -33'sd32768)
            n_s16 = 16'sh8000;
        else
            n_s16 = w_sum4[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s16 <= n_s16;
            r_l4  <= r_l3;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: zero point, int8 saturation, clamp (out_max wins if crossed)
    // 16-bit saturation of the sum is implied by the tighter int8 one
    // ------------------------------------------------------------------
    logic signed [16:0]     w_zsum;
    rq_pkg::t_int8          w_s8;
    rq_pkg::t_int8          w_lo;
    rq_pkg::t_int8          n_value;
    rq_pkg::t_int8          r_value;
    logic                   r_l5;

    assign w_zsum = {r_s16[15], r_s16} + {{9{r_out_zero[7]}}, r_out_zero};

    always_comb begin
        if (w_zsum > 17'sd127)
            w_s8 = 8'sd127;
        else if (w_zsum < -17'sd128)
            w_s8 = -8'sd128;
        else
            w_s8 = w_zsum[7:0];
        w_lo    = (w_s8 < r_out_min) ? r_out_min : w_s8;
        n_value = (w_lo > r_out_max) ? r_out_max : w_lo;
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_value <= n_value;
            r_l5    <= r_l4;
        end
    end

    assign o_value    = r_value;
    assign o_last_out = r_l5;

`ifndef SYNTHESIS
    // upstream is held off only when every stage holds a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ($countones({r_v1, r_v2, r_v3, r_v4, r_v5}) == 5))
        else $error("o_stall with a free pipeline stage");

    // a blocked stage-3 beat keeps its shift result
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_en4) |=> (r_v3 && $stable(r_fl) && $stable(r_rnd)))
        else $error("stage 3 beat changed while blocked");

    // rounding up only happens with a nonzero shift, so never on a zero shift
    a_rnd_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en3 && r_v2 && (w_sh == '0)) |=> !r_rnd)
        else $error("round bit set with zero shift");

    // a loaded output lies within uncrossed clamp bounds
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en5 && r_v4 && (r_out_min <= r_out_max))
        |=> (o_value >= $past(r_out_min)) && (o_value <= $past(r_out_max)))
        else $error("output outside clamp bounds");
`endif

endmodule
